// ===== rtl/linear_probe_hash_lookup_or_add_defines.svh =====
// assertion helpers for the hash lookup-or-add block
`ifndef LINEAR_PROBE_HASH_LOOKUP_OR_ADD_DEFINES_SVH
`define LINEAR_PROBE_HASH_LOOKUP_OR_ADD_DEFINES_SVH

// property checked on every clock edge outside reset
`define LPH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LPH_ASSERT_NEXT(lbl, ante, cons, msg) \
    `LPH_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash lookup-or-add block.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 13;
    localparam int LIMIT_W = 7;
    localparam int IDX_W   = 12;
    localparam int LVL_W   = 3;
    localparam int LEVELS  = 7;

    // key bits handled per cycle by the modulo unit
    localparam int MOD_STEP = 4;
    localparam int MOD_CYC  = KEY_W / MOD_STEP;
    localparam int MC_W     = $clog2(MOD_CYC);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd65;

    // prime table sizes; the unused last code falls back to the first size
    localparam logic [SIZE_W-1:0] SIZES [8] = '{
        13'd127, 13'd257, 13'd509, 13'd1021,
        13'd2053, 13'd4099, 13'd8191, 13'd127
    };

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MOD,
        ST_PRD,
        ST_PCHK,
        ST_KCHK,
        ST_DEC,
        ST_RKEY,
        ST_RLD,
        ST_FRD,
        ST_FCHK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_LOOK,
        PH_REINS,
        PH_INS
    } t_phase;

    // largest size level that still fits the bucket store
    function automatic logic [LVL_W-1:0] top_level(input int unsigned max_buckets);
        logic [LVL_W-1:0] lv;
        lv = '0;
        for (int i = 1; i < LEVELS; i++) begin
            if (int'(SIZES[i]) <= int'(max_buckets)) begin
                lv = LVL_W'(i);
            end
        end
        return lv;
    endfunction

endpackage

// ===== rtl/linear_probe_hash_lookup_or_add.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_lookup_or_add
// Lookup-or-add of 64-bit keys in a linear probing hash table of prime size.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one key per item. Output channel
// (o_valid/i_ready) returns one result per item: the entry number of the key,
// whether it was already stored, whether the table grew, and a full flag.
// The config channel (i_cfg_valid/o_cfg_ready) writes the load limit percent;
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. One item at a time: the home
// bucket comes from a shared modulo unit that takes 4 key bits per cycle, then
// each probe steps through bucket read, key read and compare. A growth clears
// all MAX_BUCKETS buckets one per cycle, then reinserts each stored key (key
// read, modulo, then a bucket read and check per bucket tried) before placing
// the new key. After reset all MAX_BUCKETS buckets are cleared while o_ready
// stays low; config writes are taken during that pass. A finished result
// waits while the output register holds one the receiver has not taken; the
// next item is accepted once it has moved into that register.
// ----------------------------------------------------------------------------
module linear_probe_hash_lookup_or_add #(
    parameter int MAX_ENTRIES = 4096,
    parameter int MAX_BUCKETS = 8192
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lph_pkg::KEY_W-1:0]    i_lookup_key,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lph_pkg::IDX_W-1:0]    o_entry_index,
    output logic                         o_was_present,
    output logic                         o_table_grew,
    output logic                         o_table_full,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lph_pkg::LIMIT_W-1:0]  i_load_limit_percent
);

    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int SW = EW + 1;
    localparam int CW = EW + 1;
    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int OW = CW + 20;
    localparam int KW = lph_pkg::KEY_W;
    localparam int ZW = lph_pkg::SIZE_W;
    localparam int IW = lph_pkg::IDX_W;
    localparam int LW = lph_pkg::LVL_W;
    localparam int MW = lph_pkg::MC_W;
    localparam logic [LW-1:0] TOP_LVL = lph_pkg::top_level(MAX_BUCKETS);

    // memories
    logic [SW-1:0] bkt_mem [MAX_BUCKETS];
    logic [KW-1:0] key_mem [MAX_ENTRIES];

    logic          bkt_we;
    logic [AW-1:0] bkt_waddr;
    logic [SW-1:0] bkt_wdata;
    logic [AW-1:0] bkt_raddr;
    logic          key_we;
    logic [EW-1:0] key_waddr;
    logic [EW-1:0] key_raddr;

    // control registers
    lph_pkg::t_state r_state, n_state;
    lph_pkg::t_phase r_phase, n_phase;
    logic [LW-1:0]   r_level, n_level;
    logic [CW-1:0]   r_count, n_count;
    logic [lph_pkg::LIMIT_W-1:0] r_limit;
    logic            r_ovalid, n_ovalid;
    logic            r_grow, n_grow;
    logic [AW-1:0]   r_clr, n_clr;
    logic [MW-1:0]   r_mcnt, n_mcnt;

    // payload registers
    logic [KW-1:0]   r_key, n_key;
    logic [KW-1:0]   r_mkey, n_mkey;
    logic [ZW-1:0]   r_rem, n_rem;
    logic [ZW-1:0]   r_b, n_b;
    logic [ZW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_e, n_e;
    logic [SW-1:0]   r_bdata;
    logic [KW-1:0]   r_kdata;
    logic [IW-1:0]   r_res_idx, n_res_idx;
    logic            r_res_was, n_res_was;
    logic            r_res_grew, n_res_grew;
    logic            r_res_full, n_res_full;
    logic [IW-1:0]   r_o_idx, n_o_idx;
    logic            r_o_was, n_o_was;
    logic            r_o_grew, n_o_grew;
    logic            r_o_full, n_o_full;

    // shared conditions
    logic [ZW-1:0] cur_sz;
    logic [ZW-1:0] mod_rem;
    logic [ZW-1:0] b_next;
    logic [EW-1:0] slot_entry;
    logic          slot_zero;
    logic          key_hit;
    logic          last_probe;
    logic          mod_last;
    logic          clr_done;
    logic          can_grow;
    logic          packed_tbl;
    logic          over_load;
    logic          full_out;
    logic          do_grow;
    logic          reins_last;
    logic          out_free;
    logic [OW-1:0] load_lhs;
    logic [OW-1:0] load_rhs;

    assign cur_sz     = lph_pkg::SIZES[r_level];
    assign b_next     = (r_b + ZW'(1) == cur_sz) ? '0 : r_b + ZW'(1);
    assign slot_zero  = (r_bdata == '0);
    assign slot_entry = EW'(r_bdata - SW'(1));
    assign key_hit    = (r_kdata == r_key);
    assign last_probe = (r_n + ZW'(1) == cur_sz);
    assign mod_last   = (r_mcnt == MW'(lph_pkg::MOD_CYC - 1));
    assign clr_done   = (r_clr == AW'(MAX_BUCKETS - 1));
    assign can_grow   = (r_level < TOP_LVL);
    assign packed_tbl = (OW'(r_count) >= OW'(cur_sz));
    assign load_lhs   = OW'(r_count) * OW'(100);
    assign load_rhs   = OW'(r_limit) * OW'(cur_sz);
    assign over_load  = (load_lhs > load_rhs);
    assign full_out   = (r_count == CW'(MAX_ENTRIES)) || (packed_tbl && !can_grow);
    assign do_grow    = can_grow && (over_load || packed_tbl);
    assign reins_last = (r_e + CW'(1) == r_count);
    assign out_free   = !r_ovalid || i_ready;

    // modulo unit: MOD_STEP restoring steps of key mod size per cycle
    always_comb begin
        logic [ZW:0]   t;
        logic [ZW-1:0] rv;
        rv = r_rem;
        t  = '0;
        for (int i = 0; i < lph_pkg::MOD_STEP; i++) begin
            t = {rv, r_mkey[KW-1-i]};
            if (t >= {1'b0, cur_sz}) begin
                t = t - {1'b0, cur_sz};
            end
            rv = t[ZW-1:0];
        end
        mod_rem = rv;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lph_pkg::ST_CLR: begin
                if (clr_done) begin
                    if (!r_grow) begin
                        n_state = lph_pkg::ST_IDLE;
                    end else if (r_count == '0) begin
                        n_state = lph_pkg::ST_MOD;
                    end else begin
                        n_state = lph_pkg::ST_RKEY;
                    end
                end
            end
            lph_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = lph_pkg::ST_MOD;
                end
            end
            lph_pkg::ST_MOD: begin
                if (mod_last) begin
                    n_state = (r_phase == lph_pkg::PH_LOOK) ? lph_pkg::ST_PRD
                                                            : lph_pkg::ST_FRD;
                end
            end
            lph_pkg::ST_PRD:  n_state = lph_pkg::ST_PCHK;
            lph_pkg::ST_PCHK: begin
                n_state = slot_zero ? lph_pkg::ST_DEC : lph_pkg::ST_KCHK;
            end
            lph_pkg::ST_KCHK: begin
                if (key_hit) begin
                    n_state = lph_pkg::ST_DONE;
                end else if (last_probe) begin
                    n_state = lph_pkg::ST_DEC;
                end else begin
                    n_state = lph_pkg::ST_PRD;
                end
            end
            lph_pkg::ST_DEC: begin
                if (full_out) begin
                    n_state = lph_pkg::ST_DONE;
                end else if (do_grow) begin
                    n_state = lph_pkg::ST_CLR;
                end else begin
                    n_state = lph_pkg::ST_FRD;
                end
            end
            lph_pkg::ST_RKEY: n_state = lph_pkg::ST_RLD;
            lph_pkg::ST_RLD:  n_state = lph_pkg::ST_MOD;
            lph_pkg::ST_FRD:  n_state = lph_pkg::ST_FCHK;
            lph_pkg::ST_FCHK: begin
                if (!slot_zero) begin
                    n_state = lph_pkg::ST_FRD;
                end else if (r_phase == lph_pkg::PH_INS) begin
                    n_state = lph_pkg::ST_DONE;
                end else if (reins_last) begin
                    n_state = lph_pkg::ST_MOD;
                end else begin
                    n_state = lph_pkg::ST_RKEY;
                end
            end
            lph_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = lph_pkg::ST_IDLE;
                end
            end
            default: n_state = lph_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_phase    = r_phase;
        n_level    = r_level;
        n_count    = r_count;
        n_grow     = r_grow;
        n_clr      = r_clr;
        n_mcnt     = r_mcnt;
        n_key      = r_key;
        n_mkey     = r_mkey;
        n_rem      = r_rem;
        n_b        = r_b;
        n_n        = r_n;
        n_e        = r_e;
        n_res_idx  = r_res_idx;
        n_res_was  = r_res_was;
        n_res_grew = r_res_grew;
        n_res_full = r_res_full;
        n_o_idx    = r_o_idx;
        n_o_was    = r_o_was;
        n_o_grew   = r_o_grew;
        n_o_full   = r_o_full;
        n_ovalid   = r_ovalid && !i_ready;
        bkt_we     = 1'b0;
        bkt_waddr  = AW'(r_b);
        bkt_wdata  = '0;
        bkt_raddr  = AW'(r_b);
        key_we     = 1'b0;
        key_waddr  = r_count[EW-1:0];
        key_raddr  = slot_entry;
        case (r_state)
            lph_pkg::ST_CLR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (clr_done && r_grow) begin
                    n_mkey = r_key;
                    n_rem  = '0;
                    n_mcnt = '0;
                    n_phase = (r_count == '0) ? lph_pkg::PH_INS : lph_pkg::PH_REINS;
                end
            end
            lph_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_key   = i_lookup_key;
                    n_mkey  = i_lookup_key;
                    n_rem   = '0;
                    n_mcnt  = '0;
                    n_phase = lph_pkg::PH_LOOK;
                    n_grow  = 1'b0;
                end
            end
            lph_pkg::ST_MOD: begin
                n_rem  = mod_rem;
                n_mkey = r_mkey << lph_pkg::MOD_STEP;
                n_mcnt = r_mcnt + MW'(1);
                if (mod_last) begin
                    n_b = mod_rem;
                    n_n = '0;
                end
            end
            lph_pkg::ST_KCHK: begin
                if (key_hit) begin
                    n_res_idx  = IW'(slot_entry);
                    n_res_was  = 1'b1;
                    n_res_grew = 1'b0;
                    n_res_full = 1'b0;
                end else begin
                    n_b = b_next;
                    n_n = r_n + ZW'(1);
                end
            end
            lph_pkg::ST_DEC: begin
                n_phase = lph_pkg::PH_INS;
                if (full_out) begin
                    n_res_idx  = '0;
                    n_res_was  = 1'b0;
                    n_res_grew = 1'b0;
                    n_res_full = 1'b1;
                end else if (do_grow) begin
                    n_level = r_level + LW'(1);
                    n_clr   = '0;
                    n_grow  = 1'b1;
                    n_e     = '0;
                end
            end
            lph_pkg::ST_RKEY: begin
                key_raddr = r_e[EW-1:0];
            end
            lph_pkg::ST_RLD: begin
                n_mkey = r_kdata;
                n_rem  = '0;
                n_mcnt = '0;
            end
            lph_pkg::ST_FCHK: begin
                if (slot_zero) begin
                    bkt_we = 1'b1;
                    if (r_phase == lph_pkg::PH_INS) begin
                        bkt_wdata  = SW'(r_count) + SW'(1);
                        key_we     = 1'b1;
                        n_count    = r_count + CW'(1);
                        n_res_idx  = IW'(r_count);
                        n_res_was  = 1'b0;
                        n_res_grew = r_grow;
                        n_res_full = 1'b0;
                    end else begin
                        bkt_wdata = SW'(r_e) + SW'(1);
                        n_e       = r_e + CW'(1);
                        if (reins_last) begin
                            // all old keys back in place, now the new one
                            n_mkey  = r_key;
                            n_rem   = '0;
                            n_mcnt  = '0;
                            n_phase = lph_pkg::PH_INS;
                        end
                    end
                end else begin
                    n_b = b_next;
                end
            end
            lph_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_o_idx  = r_res_idx;
                    n_o_was  = r_res_was;
                    n_o_grew = r_res_grew;
                    n_o_full = r_res_full;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        r_bdata <= bkt_mem[bkt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= r_key;
        end
        r_kdata <= key_mem[key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lph_pkg::ST_CLR;
            r_phase  <= lph_pkg::PH_LOOK;
            r_level  <= '0;
            r_count  <= '0;
            r_limit  <= lph_pkg::LIMIT_RESET;
            r_ovalid <= 1'b0;
            r_grow   <= 1'b0;
            r_clr    <= '0;
            r_mcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_level  <= n_level;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_grow   <= n_grow;
            r_clr    <= n_clr;
            r_mcnt   <= n_mcnt;
            if (i_cfg_valid) begin
                r_limit <= i_load_limit_percent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_mkey     <= n_mkey;
        r_rem      <= n_rem;
        r_b        <= n_b;
        r_n        <= n_n;
        r_e        <= n_e;
        r_res_idx  <= n_res_idx;
        r_res_was  <= n_res_was;
        r_res_grew <= n_res_grew;
        r_res_full <= n_res_full;
        r_o_idx    <= n_o_idx;
        r_o_was    <= n_o_was;
        r_o_grew   <= n_o_grew;
        r_o_full   <= n_o_full;
    end

    assign o_ready       = (r_state == lph_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_entry_index = r_o_idx;
    assign o_was_present = r_o_was;
    assign o_table_grew  = r_o_grew;
    assign o_table_full  = r_o_full;

endmodule

// ===== rtl/lph_checker.sv =====
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks of the hash lookup-or-add block, bound to its top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_lookup_or_add_defines.svh"

module lph_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [11:0] o_entry_index,
    input logic        o_was_present,
    input logic        o_table_grew,
    input logic        o_table_full
);

    // a stalled result stays offered
    `LPH_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")

    // a full result carries no entry and no other flag
    `LPH_ASSERT(a_full_clean, (o_valid && o_table_full) |-> (!o_was_present && !o_table_grew && o_entry_index == 12'd0), "full result not clean")

    // a hit never reports growth
    `LPH_ASSERT(a_hit_no_grow, (o_valid && o_was_present) |-> !o_table_grew, "hit reported growth")

    // the block is busy right after taking an item
    `LPH_ASSERT_NEXT(a_busy_after_take, i_valid && o_ready, !o_ready, "ready right after accept")

endmodule

bind linear_probe_hash_lookup_or_add lph_checker u_lph_checker (.*);
